/* rtl/core/assert_macros.svh */
// Assertion helpers; every user clocks on i_clk with active-low i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge out of reset.
`define ASSERT_AT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition must never be seen out of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

/* rtl/core/pku_pkg.sv */
`timescale 1ns / 1ps
package pku_pkg;

    localparam int NUM_DESC       = 6;
    localparam int MAX_FIELDS_DEF = 6;
    localparam int DESC_W         = 36;
    localparam int FP_W           = 3;
    localparam int CFG_IDX_W      = 3;
    localparam int Q_DEPTH        = 2;
    localparam int Q_PTR_W        = 1;
    localparam int Q_CNT_W        = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_COUNT = 3'd0;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_TAG   = 3'd1;
    localparam logic [2:0] ERR_EXT   = 3'd2;
    localparam logic [2:0] ERR_SIZE  = 3'd3;
    localparam logic [2:0] ERR_GAP   = 3'd4;
    localparam logic [2:0] ERR_TRUNC = 3'd5;

    localparam logic [1:0] EXT_16 = 2'd1;
    localparam logic [1:0] EXT_32 = 2'd2;

    localparam logic [7:0] QUAL_OFFSET = 8'd33;
    localparam logic [5:0] NAME_TAG_N  = 6'd4;
    localparam logic [5:0] NAME_QV_MAX = 6'd10;
    localparam logic [5:0] NAME_QV_ALT = 6'd31;

    typedef struct packed {
        logic [5:0] name;
        logic [1:0] ext;
        logic [7:0] esc;
        logic       escen;
        logic [2:0] shift;
        logic [7:0] mask;
        logic [6:0] bits;
        logic       gap;
    } t_desc;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic        last;
        logic [2:0]  err;
        logic [31:0] value;
        logic [5:0]  name;
    } t_result;

    function automatic logic [7:0] base_letter(input logic [7:0] code);
        logic [7:0] r;
        case (code)
            8'd0:    r = 8'h41;
            8'd1:    r = 8'h43;
            8'd2:    r = 8'h47;
            8'd3:    r = 8'h54;
            8'd4:    r = 8'h4E;
            8'd5:    r = 8'h2D;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/pku_front.sv */
`timescale 1ns / 1ps
module pku_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  pku_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output pku_pkg::t_item o_item
);
    import pku_pkg::*;

    t_item               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr_ptr;
    logic [Q_PTR_W-1:0]  r_rd_ptr;
    logic [Q_CNT_W-1:0]  r_cnt;
    logic                push;
    logic                pop;

    assign o_ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* rtl/core/pku_engine.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pku_engine #(
    parameter int N_DESC = pku_pkg::NUM_DESC
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_item_valid,
    output logic                    o_item_ready,
    input  pku_pkg::t_item          i_item,
    input  logic [pku_pkg::FP_W-1:0] i_count,
    input  logic [pku_pkg::DESC_W-1:0] i_desc [N_DESC],
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output pku_pkg::t_result        o_res
);
    import pku_pkg::*;

    localparam int IDX_W = (N_DESC > 1) ? $clog2(N_DESC) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [FP_W-1:0]  r_fp, n_fp;
    logic [FP_W-1:0]  r_visit, n_visit;
    logic [2:0]       r_ext_left, n_ext_left;
    logic [31:0]      r_acc, n_acc;
    logic [3:0]       r_gap_left, n_gap_left;
    logic             r_drop, n_drop;
    logic             r_pend_v, n_pend_v;
    t_result          r_pend, n_pend;
    logic             r_ov;
    t_result          r_out;

    t_desc            d;
    logic [IDX_W-1:0] fp_idx;
    logic [7:0]       x;
    logic [FP_W-1:0]  fp_inc;
    logic [FP_W-1:0]  fp_next;
    logic             out_free;
    logic             out_push;
    t_result          out_data;
    logic             e_v;
    t_result          e_res;
    logic             consumed;
    logic             hold;
    logic [2:0]       err;
    logic             step_en;
    logic [2:0]       ext_total;
    logic [2:0]       ext_pos;
    logic [31:0]      acc_new;
    logic [2:0]       ext_dec;
    logic [3:0]       gap_load;

    assign fp_idx   = r_fp[IDX_W-1:0];
    assign d        = t_desc'(i_desc[fp_idx]);
    assign x        = (r_byte & d.mask) >> d.shift;
    assign fp_inc   = r_fp + 1'b1;
    assign fp_next  = (fp_inc == i_count) ? '0 : fp_inc;
    assign out_free = !r_ov || i_res_ready;
    assign step_en  = !r_pend_v || out_free;
    assign o_item_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_ov;
    assign o_res        = r_out;

    always_comb begin
        n_state    = r_state;
        n_fp       = r_fp;
        n_visit    = r_visit;
        n_ext_left = r_ext_left;
        n_acc      = r_acc;
        n_gap_left = r_gap_left;
        n_drop     = r_drop;
        n_pend_v   = r_pend_v;
        n_pend     = r_pend;
        out_push   = 1'b0;
        out_data   = r_pend;
        e_v        = 1'b0;
        e_res      = '0;
        consumed   = 1'b0;
        hold       = 1'b0;
        err        = ERR_OK;
        ext_total  = (d.ext == EXT_16) ? 3'd2 : 3'd4;
        ext_pos    = ext_total - r_ext_left;
        acc_new    = r_acc | ({24'b0, r_byte} << {ext_pos[1:0], 3'b000});
        ext_dec    = r_ext_left - 1'b1;
        gap_load   = d.bits[6:3] - 1'b1;
        e_res.name = d.name;

        case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_visit = '0;
                    if (r_fp >= i_count) begin
                        n_fp = '0;
                    end
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (step_en) begin
                    if (r_drop) begin
                        n_state = S_DONE;
                    end else if (r_ext_left != '0) begin
                        n_acc      = acc_new;
                        n_ext_left = ext_dec;
                        if (ext_dec == '0) begin
                            e_v         = 1'b1;
                            e_res.value = acc_new;
                            n_fp        = fp_next;
                        end else if (r_last) begin
                            e_v       = 1'b1;
                            e_res.err = ERR_TRUNC;
                        end
                        n_state = S_DONE;
                    end else if (r_gap_left != '0) begin
                        n_gap_left = r_gap_left - 1'b1;
                        if (r_gap_left == 4'd1) begin
                            n_fp = fp_next;
                        end
                        n_state = S_DONE;
                    end else begin
                        // one descriptor visit
                        if (d.gap) begin
                            if (d.bits < 7'd8) begin
                                consumed = (d.shift == '0);
                            end else if (d.bits[2:0] == 3'd0) begin
                                consumed   = 1'b1;
                                n_gap_left = gap_load;
                                hold       = (gap_load != '0);
                            end else begin
                                err = ERR_GAP;
                            end
                        end else if (d.bits == 7'd1) begin
                            e_v         = 1'b1;
                            e_res.value = {24'b0, x};
                            consumed    = (d.shift == '0);
                        end else if (d.bits < 7'd8) begin
                            if (d.name < NAME_TAG_N) begin
                                if (x > 8'd4) begin
                                    err = ERR_TAG;
                                end else begin
                                    e_v         = 1'b1;
                                    e_res.value = {24'b0, base_letter(x)};
                                end
                            end else if (d.name == NAME_TAG_N) begin
                                if (x > 8'd5) begin
                                    err = ERR_TAG;
                                end else begin
                                    e_v         = 1'b1;
                                    e_res.value = {24'b0, base_letter(x)};
                                end
                            end else if (d.name <= NAME_QV_MAX || d.name == NAME_QV_ALT) begin
                                e_v         = 1'b1;
                                e_res.value = {24'b0, x} + {24'b0, QUAL_OFFSET};
                            end
                            consumed = (err == ERR_OK) && (d.shift == '0);
                        end else if (d.bits == 7'd8) begin
                            if (!d.escen || r_byte < d.esc) begin
                                e_v         = 1'b1;
                                e_res.value = {24'b0, r_byte};
                                consumed    = 1'b1;
                            end else if (d.ext == EXT_16 || d.ext == EXT_32) begin
                                consumed = 1'b1;
                                if (r_last) begin
                                    err = ERR_TRUNC;
                                end else begin
                                    n_ext_left = (d.ext == EXT_16) ? 3'd2 : 3'd4;
                                    n_acc      = '0;
                                    hold       = 1'b1;
                                end
                            end else begin
                                err = ERR_EXT;
                            end
                        end else begin
                            err = ERR_SIZE;
                        end

                        if (err != ERR_OK) begin
                            e_v         = 1'b1;
                            e_res.value = '0;
                            e_res.err   = err;
                            n_drop      = 1'b1;
                            n_state     = S_DONE;
                        end else begin
                            if (!hold) begin
                                n_fp = fp_next;
                            end
                            if (consumed || (r_visit + 1'b1 == i_count)) begin
                                n_state = S_DONE;
                            end else begin
                                n_visit = r_visit + 1'b1;
                            end
                        end
                    end

                    // a new result pushes the held one out; it was not the last
                    if (e_v) begin
                        if (r_pend_v) begin
                            out_push      = 1'b1;
                            out_data      = r_pend;
                            out_data.last = 1'b0;
                        end
                        n_pend_v = 1'b1;
                        n_pend   = e_res;
                    end
                end
            end
            S_DONE: begin
                if (!r_pend_v || out_free) begin
                    if (r_pend_v) begin
                        out_push      = 1'b1;
                        out_data      = r_pend;
                        out_data.last = 1'b1;
                        n_pend_v      = 1'b0;
                    end
                    if (r_last) begin
                        n_fp       = '0;
                        n_ext_left = '0;
                        n_acc      = '0;
                        n_gap_left = '0;
                        n_drop     = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_item_valid) begin
            r_byte <= i_item.data;
            r_last <= i_item.last;
        end
        r_pend <= n_pend;
        if (out_push) begin
            r_out <= out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fp       <= '0;
            r_visit    <= '0;
            r_ext_left <= '0;
            r_acc      <= '0;
            r_gap_left <= '0;
            r_drop     <= 1'b0;
            r_pend_v   <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fp       <= n_fp;
            r_visit    <= n_visit;
            r_ext_left <= n_ext_left;
            r_acc      <= n_acc;
            r_gap_left <= n_gap_left;
            r_drop     <= n_drop;
            r_pend_v   <= n_pend_v;
            if (out_push) begin
                r_ov <= 1'b1;
            end else if (i_res_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    `ASSERT_AT(a_ext_exclusive, (r_ext_left != '0) |-> (r_gap_left == '0 && !r_drop), "ext overlap")
    `ASSERT_NEVER(a_idle_pending, (r_state == S_IDLE) && r_pend_v, "result held while idle")
    `ASSERT_AT(a_done_flush, (r_state == S_DONE && out_push) |=> !r_pend_v, "closing beat left a result")

endmodule

/* rtl/core/packet_field_unpacker.sv */
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Payload
// s (in)    in   i_s_tvalid / o_s_tready   tdata[7:0] data_byte, tlast stream_end
// m (out)   out  o_m_tvalid / i_m_tready   tdata field_name, field_value; tuser error_code;
//                                          tlast last_of_byte
// cfg       in   i_cfg_valid / o_cfg_ready i_cfg_index register, i_cfg_data value
//
// A byte passes a load state, one walk step per descriptor visited (1 to field_count,
// capped at N_DESC) and a closing state that releases its final result. One descriptor
// is visited a cycle unless the output stalls; gap, extension and dropped bytes visit none.
// Synchronous reset sets field_count to 1 and clears descriptors and walk state.
// A stalled output holds the engine once its held result cannot move; the input
// queue keeps taking up to two beats meanwhile.
module packet_field_unpacker #(
    parameter int MAX_FIELDS = pku_pkg::MAX_FIELDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [5:0] field_name, [37:6] field_value, [39:38] zero
    output logic [2:0]  o_m_tuser,   // [2:0] error_code
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [pku_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pku_pkg::DESC_W-1:0]    i_cfg_data
);
    import pku_pkg::*;

    localparam int N_DESC = (MAX_FIELDS < NUM_DESC) ? MAX_FIELDS : NUM_DESC;

    logic [FP_W-1:0]   r_field_count;
    logic [DESC_W-1:0] r_desc [N_DESC];
    logic [FP_W-1:0]   count_eff;
    logic              cfg_we;
    t_item             in_item;
    t_item             q_item;
    logic              q_valid;
    logic              q_ready;
    t_result           res;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        count_eff = r_field_count;
        if (r_field_count > FP_W'(N_DESC)) begin
            count_eff = FP_W'(N_DESC);
        end
        if (r_field_count == '0) begin
            count_eff = FP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= FP_W'(1);
            for (int i = 0; i < N_DESC; i++) begin
                r_desc[i] <= '0;
            end
        end else if (cfg_we) begin
            if (i_cfg_index == CFG_FIELD_COUNT) begin
                r_field_count <= i_cfg_data[FP_W-1:0];
            end
            for (int i = 0; i < N_DESC; i++) begin
                if (i_cfg_index == CFG_IDX_W'(i + 1)) begin
                    r_desc[i] <= i_cfg_data;
                end
            end
        end
    end

    assign in_item.data = i_s_tdata;
    assign in_item.last = i_s_tlast;

    pku_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (in_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    pku_engine #(
        .N_DESC (N_DESC)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (q_valid),
        .o_item_ready (q_ready),
        .i_item       (q_item),
        .i_count      (count_eff),
        .i_desc       (r_desc),
        .o_res_valid  (o_m_tvalid),
        .i_res_ready  (i_m_tready),
        .o_res        (res)
    );

    assign o_m_tdata = {2'b00, res.value, res.name};
    assign o_m_tuser = res.err;
    assign o_m_tlast = res.last;

endmodule

/* sim/tb_packet_field_unpacker.sv */
`timescale 1ns / 1ps
module tb_packet_field_unpacker;
    import pku_pkg::*;

    localparam int          LAP_LIMIT    = (MAX_FIELDS_DEF < NUM_DESC) ? MAX_FIELDS_DEF : NUM_DESC;
    localparam int          DRAIN_CYCLES = 50;
    localparam int          PHASE_BYTES  = 18;
    localparam int          TIMEOUT_NS   = 3_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_DESC_BASE = 3'd1;
    localparam logic [1:0]  EXT_NONE     = 2'd0;
    localparam logic [1:0]  EXT_BAD      = 2'd3;
    localparam logic [7:0]  CODE_N       = 8'd4;
    localparam logic [7:0]  CODE_DASH    = 8'd5;
    // A C G T N -
    localparam logic [7:0]  BASE_LETTERS [0:5] = '{8'h41, 8'h43, 8'h47, 8'h54, 8'h4E, 8'h2D};

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = 8'h00;
    logic        i_s_tlast   = 1'b0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [39:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DESC_W-1:0]    i_cfg_data  = '0;

    // Shadow copy of the unpacker: configuration and walk state
    logic [2:0]  model_count = 3'd1;
    t_desc       model_desc [NUM_DESC] = '{default: '0};
    int unsigned walk_ptr    = 0;
    int unsigned ext_left    = 0;
    logic [31:0] ext_acc     = '0;
    int unsigned gap_left    = 0;
    bit          dropping    = 1'b0;

    t_desc       next_desc [NUM_DESC] = '{default: '0};
    t_result     byte_results [$];
    t_result     expected_fields [$];
    int          fail_count     = 0;
    int          send_idle_pct  = 7;
    int          ready_idle_pct = 7;

    packet_field_unpacker DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= ready_idle_pct);
    end

    always @(posedge i_clk) begin : check_result_beat
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_fields.size() == 0) begin
                $error("result beat with nothing pending: field_name %0d field_value %0h error_code %0d",
                       o_m_tdata[5:0], o_m_tdata[37:6], o_m_tuser);
                fail_count++;
            end else begin
                want = expected_fields.pop_front();
                if (o_m_tdata[5:0] !== want.name) begin
                    $error("field_name: expected %0d actual %0d", want.name, o_m_tdata[5:0]);
                    fail_count++;
                end
                if (o_m_tdata[37:6] !== want.value) begin
                    $error("field_value: expected %0h actual %0h", want.value, o_m_tdata[37:6]);
                    fail_count++;
                end
                if (o_m_tuser !== want.err) begin
                    $error("error_code: expected %0d actual %0d", want.err, o_m_tuser);
                    fail_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_of_byte: expected %0b actual %0b", want.last, o_m_tlast);
                    fail_count++;
                end
            end
        end
    end

    function automatic void emit_field(input logic [5:0] name, input logic [31:0] value,
                                       input logic [2:0] err);
        t_result r;
        r.name  = name;
        r.value = value;
        r.err   = err;
        r.last  = 1'b0;
        if (byte_results.size() < NUM_DESC) byte_results.insert(byte_results.size(), r);
    endfunction

    // Walk the descriptor ring for one accepted byte and queue the fields it yields.
    function automatic void predict_fields(input logic [7:0] data, input logic stream_end);
        t_desc       d;
        int unsigned lap_len;
        int unsigned total;
        int unsigned pos;
        int unsigned v;
        logic [7:0]  x;
        logic [2:0]  err;
        bit          consumed;
        bit          hold;
        byte_results.delete();
        lap_len = (model_count > LAP_LIMIT) ? LAP_LIMIT : model_count;
        if (lap_len == 0) lap_len = 1;
        if (walk_ptr >= lap_len) walk_ptr = 0;

        if (dropping) begin
            // discard until the stream ends
        end else if (ext_left != 0) begin
            d     = model_desc[walk_ptr];
            total = (d.ext == EXT_16) ? 2 : 4;
            pos   = (total - ext_left) & 3;
            ext_acc |= 32'(data) << (8 * pos);
            ext_left--;
            if (ext_left == 0) begin
                emit_field(d.name, ext_acc, ERR_OK);
                walk_ptr = (walk_ptr + 1) % lap_len;
            end else if (stream_end) begin
                emit_field(d.name, 32'd0, ERR_TRUNC);
            end
        end else if (gap_left != 0) begin
            gap_left--;
            if (gap_left == 0) walk_ptr = (walk_ptr + 1) % lap_len;
        end else begin
            for (v = 0; v < lap_len; v++) begin
                d        = model_desc[walk_ptr];
                x        = (data & d.mask) >> d.shift;
                consumed = 1'b0;
                hold     = 1'b0;
                err      = ERR_OK;
                if (d.gap) begin
                    if (d.bits < 8) begin
                        consumed = (d.shift == 0);
                    end else if (d.bits[2:0] == 3'd0) begin
                        consumed = 1'b1;
                        gap_left = (d.bits >> 3) - 1;
                        hold     = (gap_left != 0);
                    end else begin
                        err = ERR_GAP;
                    end
                end else if (d.bits == 1) begin
                    emit_field(d.name, 32'(x), ERR_OK);
                    consumed = (d.shift == 0);
                end else if (d.bits < 8) begin
                    if (d.name < NAME_TAG_N) begin
                        if (x > CODE_N) err = ERR_TAG;
                        else emit_field(d.name, 32'(BASE_LETTERS[x]), ERR_OK);
                    end else if (d.name == NAME_TAG_N) begin
                        if (x > CODE_DASH) err = ERR_TAG;
                        else emit_field(d.name, 32'(BASE_LETTERS[x]), ERR_OK);
                    end else if (d.name <= NAME_QV_MAX || d.name == NAME_QV_ALT) begin
                        emit_field(d.name, 32'(x) + 32'(QUAL_OFFSET), ERR_OK);
                    end
                    consumed = (err == ERR_OK) && (d.shift == 0);
                end else if (d.bits == 8) begin
                    if (!d.escen || data < d.esc) begin
                        emit_field(d.name, 32'(data), ERR_OK);
                        consumed = 1'b1;
                    end else if (d.ext == EXT_16 || d.ext == EXT_32) begin
                        consumed = 1'b1;
                        if (stream_end) begin
                            err = ERR_TRUNC;
                        end else begin
                            ext_left = (d.ext == EXT_16) ? 2 : 4;
                            ext_acc  = '0;
                            hold     = 1'b1;
                        end
                    end else begin
                        err = ERR_EXT;
                    end
                end else begin
                    err = ERR_SIZE;
                end

                if (err != ERR_OK) begin
                    emit_field(d.name, 32'd0, err);
                    dropping = 1'b1;
                    break;
                end
                if (!hold) walk_ptr = (walk_ptr + 1) % lap_len;
                if (consumed) break;
            end
        end

        if (stream_end) begin
            walk_ptr = 0;
            ext_left = 0;
            ext_acc  = '0;
            gap_left = 0;
            dropping = 1'b0;
        end
        if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last = 1'b1;
        foreach (byte_results[i]) expected_fields.insert(expected_fields.size(), byte_results[i]);
    endfunction

    function automatic t_desc make_desc(input logic [5:0] name, input logic [6:0] bits,
                                        input logic [7:0] mask, input logic [2:0] shift,
                                        input logic gap = 1'b0, input logic escen = 1'b0,
                                        input logic [7:0] esc = 8'h00,
                                        input logic [1:0] ext = EXT_NONE);
        t_desc d;
        d.name  = name;
        d.bits  = bits;
        d.mask  = mask;
        d.shift = shift;
        d.gap   = gap;
        d.escen = escen;
        d.esc   = esc;
        d.ext   = ext;
        return d;
    endfunction

    // Favor shift 0 so that sub-byte rings consume bytes often
    function automatic logic [2:0] pick_shift(input int top);
        return ($urandom_range(0, 9) < 4) ? 3'd0 : 3'($urandom_range(1, top));
    endfunction

    function automatic t_desc random_desc();
        t_desc d;
        int    kind;
        d      = '0;
        kind   = $urandom_range(0, 99);
        d.name = 6'($urandom_range(0, 63));
        d.mask = 8'($urandom_range(0, 255));
        if (kind < 6) begin
            d = {4'($urandom_range(0, 15)), 32'($urandom)};
        end else if (kind < 18) begin
            d.bits  = 7'd1;
            d.shift = pick_shift(7);
        end else if (kind < 36) begin
            d.name  = 6'($urandom_range(0, 4));
            d.bits  = 7'($urandom_range(1, 7));
            if (d.bits == 1) d.bits = 7'd0;
            d.shift = pick_shift(6);
            d.mask  = 8'h03 << d.shift;
            // wider code field on the N/gap tag can exceed the letter table
            if (d.name == NAME_TAG_N && $urandom_range(0, 3) == 0) d.mask = 8'h07 << d.shift;
        end else if (kind < 48) begin
            d.name  = ($urandom_range(0, 6) == 6) ? NAME_QV_ALT : 6'($urandom_range(5, 10));
            d.bits  = 7'($urandom_range(2, 7));
            d.shift = pick_shift(7);
        end else if (kind < 56) begin
            d.name  = 6'($urandom_range(11, 30));
            d.bits  = 7'($urandom_range(2, 7));
            d.shift = pick_shift(7);
        end else if (kind < 70) begin
            d.bits  = 7'd8;
            d.escen = 1'($urandom_range(0, 1));
            d.esc   = 8'($urandom_range(0, 255));
        end else if (kind < 84) begin
            d.bits  = 7'd8;
            d.escen = 1'b1;
            d.esc   = 8'($urandom_range(8'hC0, 8'hFF));
            d.ext   = ($urandom_range(0, 1) == 0) ? EXT_16 : EXT_32;
            if ($urandom_range(0, 9) == 0) d.ext = ($urandom_range(0, 1) == 0) ? EXT_NONE : EXT_BAD;
        end else if (kind < 94) begin
            d.gap  = 1'b1;
            d.bits = ($urandom_range(0, 9) == 0) ? 7'd120 : 7'(8 * $urandom_range(1, 3));
        end else begin
            d.gap   = 1'b1;
            d.bits  = 7'($urandom_range(0, 7));
            d.shift = pick_shift(7);
        end
        return d;
    endfunction

    task automatic send_byte(input logic [7:0] data, input logic stream_end);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= data;
        i_s_tlast  <= stream_end;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_fields(data, stream_end);
    endtask

    task automatic wait_drain();
        while (expected_fields.size() != 0) @(posedge i_clk);
        // bytes that yield no field may still be in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DESC_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == CFG_FIELD_COUNT) model_count = value[2:0];
        else model_desc[index - CFG_DESC_BASE] = value;
    endtask

    task automatic load_config(input logic [2:0] count);
        int k;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_drain();
        write_reg(CFG_FIELD_COUNT, DESC_W'(count));
        for (k = 0; k < NUM_DESC; k++) write_reg(CFG_IDX_W'(CFG_DESC_BASE + k), next_desc[k]);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        // all-zero descriptor: zero-width tag field, every byte reads as 'A'
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    task automatic test_subbyte_fields();
        next_desc[0] = make_desc(6'd12, 7'd1, 8'h80, 3'd7);
        next_desc[1] = make_desc(NAME_TAG_N, 7'd3, 8'h70, 3'd4);
        next_desc[2] = make_desc(6'd7, 7'd2, 8'h0C, 3'd2);
        next_desc[3] = make_desc(6'd20, 7'd2, 8'h03, 3'd0);
        next_desc[4] = make_desc(6'd40, 7'd8, 8'hFF, 3'd0);
        next_desc[5] = '0;
        load_config(3'd5);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hD5, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h12, 1'b1);
    endtask

    task automatic test_escape_and_gap();
        next_desc[0] = make_desc(6'd2, 7'd8, 8'hFF, 3'd0, 1'b0, 1'b1, 8'hF0, EXT_16);
        next_desc[1] = make_desc(6'd33, 7'd8, 8'hFF, 3'd0, 1'b0, 1'b1, 8'hFE, EXT_32);
        next_desc[2] = make_desc(6'd50, 7'd16, 8'h00, 3'd0, 1'b1);
        load_config(3'd3);
        send_byte(8'hF5, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'hBB, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h10, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h56, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hF0, 1'b1);
    endtask

    task automatic test_error_codes();
        t_desc      bad_desc [4];
        logic [7:0] bad_byte [4];
        int         i;
        bad_desc[0] = make_desc(6'd0, 7'd3, 8'h07, 3'd0);
        bad_desc[1] = make_desc(6'd3, 7'd8, 8'hFF, 3'd0, 1'b0, 1'b1, 8'h80, EXT_BAD);
        bad_desc[2] = make_desc(6'd15, 7'd9, 8'hFF, 3'd0);
        bad_desc[3] = make_desc(6'd16, 7'd12, 8'h00, 3'd0, 1'b1);
        bad_byte    = '{8'h07, 8'hFF, 8'h3C, 8'hC3};
        for (i = 0; i < 4; i++) begin
            next_desc[0] = bad_desc[i];
            load_config(3'd1);
            send_byte(bad_byte[i], 1'(i >= 2));
            // drop the rest of the stream
            if (i < 2) send_byte(8'h5A, 1'b1);
        end
    endtask

    task automatic test_count_limits();
        next_desc[0] = make_desc(6'd9, 7'd8, 8'hFF, 3'd0, 1'b0, 1'b1, 8'h80, EXT_32);
        load_config(3'd0);
        send_byte(8'h05, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h11, 1'b0);
        // swap the descriptor under a half-read extension
        next_desc[0] = make_desc(6'd21, 7'd8, 8'hFF, 3'd0, 1'b0, 1'b1, 8'h80, EXT_BAD);
        next_desc[1] = make_desc(6'd63, 7'd8, 8'hFF, 3'd0);
        load_config(3'd7);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
        send_byte(8'h7E, 1'b0);
        // shrink the ring below the pointer; no descriptor consumes the byte
        next_desc[0] = make_desc(6'd13, 7'd1, 8'h08, 3'd3);
        next_desc[1] = make_desc(6'd5, 7'd7, 8'hFE, 3'd1);
        load_config(3'd2);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_random_streams();
        logic [2:0] phase_count [5];
        int         stream_left;
        int         p;
        int         k;
        phase_count = '{3'd6, 3'd1, 3'd7, 3'd0, 3'($urandom_range(2, 5))};
        stream_left = 0;
        for (p = 0; p < 5; p++) begin
            for (k = 0; k < NUM_DESC; k++) next_desc[k] = random_desc();
            load_config(phase_count[p]);
            send_idle_pct  = (p == 2) ? 0 : 7;
            ready_idle_pct = (p == 2) ? 0 : 7;
            for (k = 0; k < PHASE_BYTES; k++) begin
                if (stream_left == 0) stream_left = $urandom_range(1, 12);
                stream_left--;
                send_byte(8'($urandom_range(0, 255)), stream_left == 0);
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_subbyte_fields();
        test_escape_and_gap();
        test_error_codes();
        test_count_limits();
        test_random_streams();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        wait_drain();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
